>>> src/sabf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabf_pkg
// Types and constants shared by the shadow alpha box filter modules.
// ----------------------------------------------------------------------------
package sabf_pkg;

  localparam int ALPHA_W = 8;
  localparam int POS_W   = 8;
  localparam int R_W     = 4;
  localparam int DIM_W   = 9;
  localparam int CNT_W   = R_W + 1;
  localparam int COORD_W = POS_W + 2;
  localparam int SUM_W   = 18;
  localparam int DIV_W   = 10;
  localparam int DCNT_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = 9;

  localparam logic [DIV_W-1:0]   DIV_EXTRA = 10'd4;
  localparam logic [SUM_W-1:0]   ALPHA_CAP = 18'd255;
  localparam logic [R_W-1:0]     RADIUS_RST = 4'd8;
  localparam logic [DIM_W-1:0]   DIM_RST = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr;
    logic load;
    logic step;
    logic div_init;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
  } dp_status_t;

endpackage

>>> src/sabf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabf_ctrl
// Sequencer: write strobe for each write item; window scan, flush, divide and result strobe for each query.
// ----------------------------------------------------------------------------
module sabf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_func,
  input  sabf_pkg::dp_status_t   status,
  output sabf_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);
  import sabf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func == FUNC_QUERY) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_FLUSH;
      end
      ST_FLUSH:    state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status.div_last) state_nxt = ST_DONE;
      end
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.wr   = accept && (in_func == FUNC_WRITE);
        cmd.load = accept && (in_func == FUNC_QUERY);
      end
      ST_SCAN:     cmd.step = 1'b1;
      ST_FLUSH:    cmd = '0;
      ST_DIV_LOAD: cmd.div_init = 1'b1;
      ST_DIVIDE:   cmd.div_step = 1'b1;
      ST_DONE:     cmd.emit = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

>>> src/sabf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sabf_dp
// Alpha plane memory, config registers, window walk, accumulator and
// restoring divider.
// ----------------------------------------------------------------------------
module sabf_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sabf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sabf_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [sabf_pkg::POS_W-1:0]          in_x_pos,
  input  logic [sabf_pkg::POS_W-1:0]          in_y_pos,
  input  logic [sabf_pkg::ALPHA_W-1:0]        in_alpha_in,
  input  sabf_pkg::ctrl_cmd_t                 cmd,
  output sabf_pkg::dp_status_t                status,
  output logic                                out_strobe,
  output logic [sabf_pkg::ALPHA_W-1:0]        out_shadow_alpha
);
  import sabf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ALPHA_W-1:0] mem [DEPTH];

  logic [R_W-1:0]     radius_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;

  logic [POS_W-1:0]   x_r;
  logic [POS_W-1:0]   y_r;
  logic [R_W-1:0]     r_r;
  logic [DIM_W-1:0]   w_r;
  logic [DIM_W-1:0]   h_r;
  logic [CNT_W-1:0]   di_r;
  logic [CNT_W-1:0]   dj_r;
  logic [DIV_W-1:0]   divisor_r;
  logic               hit_r;
  logic [ALPHA_W-1:0] rd_data_r;
  logic [SUM_W-1:0]   acc_r;
  logic [DIV_W:0]     rem_r;
  logic [SUM_W-1:0]   quo_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic               out_strobe_r;
  logic [ALPHA_W-1:0] out_alpha_r;

  logic [R_W-1:0]     r_eff;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [CNT_W-1:0]   side_eff;
  logic [DIV_W-1:0]   sq_eff;
  logic [CNT_W-1:0]   span;
  logic signed [COORD_W-1:0] pos_i;
  logic signed [COORD_W-1:0] pos_j;
  logic               inb;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_ok;
  logic [DIV_W:0]     shifted;
  logic               fits;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      width_r  <= DIM_RST;
      height_r <= DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r <= cfg_wdata[R_W-1:0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign r_eff = (int'(radius_r) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : radius_r;
  assign w_eff = (int'(width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_r;
  assign h_eff = (int'(height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_r;
  assign side_eff = {r_eff, 1'b1};
  assign sq_eff   = DIV_W'(side_eff) * DIV_W'(side_eff);

  // window walk
  assign span  = {r_r, 1'b0};
  assign pos_i = $signed({2'b00, x_r}) - $signed(COORD_W'(r_r)) + $signed(COORD_W'(di_r));
  assign pos_j = $signed({2'b00, y_r}) - $signed(COORD_W'(r_r)) + $signed(COORD_W'(dj_r));
  assign inb   = !pos_i[COORD_W-1] && !pos_j[COORD_W-1]
              && (pos_i[COORD_W-2:0] < COORD_W'(w_r) - COORD_W'(0))
              && (pos_j[COORD_W-2:0] < COORD_W'(h_r) - COORD_W'(0));
  assign rd_addr = AW'(pos_j[COORD_W-2:0]) * AW'(MAX_WIDTH) + AW'(pos_i[COORD_W-2:0]);

  assign wr_ok   = (int'(in_x_pos) < MAX_WIDTH) && (int'(in_y_pos) < MAX_HEIGHT);
  assign wr_addr = AW'(in_y_pos) * AW'(MAX_WIDTH) + AW'(in_x_pos);

  assign status.scan_last = (di_r == span) && (dj_r == span);
  assign status.div_last  = (dcnt_r == DCNT_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) mem[wr_addr] <= in_alpha_in;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= in_x_pos;
      y_r       <= in_y_pos;
      r_r       <= r_eff;
      w_r       <= w_eff;
      h_r       <= h_eff;
      divisor_r <= sq_eff + DIV_EXTRA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      di_r  <= '0;
      dj_r  <= '0;
      hit_r <= 1'b0;
      acc_r <= '0;
    end else begin
      hit_r <= cmd.step && inb;
      if (cmd.load) begin
        di_r  <= '0;
        dj_r  <= '0;
        acc_r <= '0;
      end else begin
        if (cmd.step) begin
          if (di_r == span) begin
            di_r <= '0;
            dj_r <= dj_r + 1'b1;
          end else begin
            di_r <= di_r + 1'b1;
          end
        end
        if (hit_r) acc_r <= acc_r + SUM_W'(rd_data_r);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign shifted = {rem_r[DIV_W-1:0], quo_r[SUM_W-1]};
  assign fits    = shifted >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_init) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= acc_r;
    end else if (cmd.div_step) begin
      rem_r <= fits ? (shifted - {1'b0, divisor_r}) : shifted;
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_alpha_r <= (quo_r > ALPHA_CAP) ? ALPHA_CAP[ALPHA_W-1:0] : quo_r[ALPHA_W-1:0];
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_shadow_alpha = out_alpha_r;

endmodule

>>> src/shadow_alpha_box_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_alpha_box_filter
// Drop-shadow alpha from a box-averaged alpha plane held in on-chip memory.
//
//   channel  ports                                   handshake
//   input    in_func in_x_pos in_y_pos in_alpha_in   start & !busy
//   result   out_shadow_alpha                        out_strobe, one cycle
//   config   cfg_index cfg_wdata                     cfg_we
//
// A write item leaves busy low.
// A query item holds busy through one memory read per window position on the
// single read port, then the bit-serial divider; out_strobe rises at the same
// edge at which busy falls.
// Reset is synchronous; the memory is not cleared.
// The receiver cannot stall; out_shadow_alpha holds each result until the next query's result is emitted.
// ----------------------------------------------------------------------------
module shadow_alpha_box_filter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [sabf_pkg::POS_W-1:0]          in_x_pos,
  input  logic [sabf_pkg::POS_W-1:0]          in_y_pos,
  input  logic [sabf_pkg::ALPHA_W-1:0]        in_alpha_in,
  output logic                                out_strobe,
  output logic [sabf_pkg::ALPHA_W-1:0]        out_shadow_alpha,
  input  logic                                cfg_we,
  input  logic [sabf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sabf_pkg::CFG_W-1:0]          cfg_wdata
);
  import sabf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sabf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  sabf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_x_pos         (in_x_pos),
    .in_y_pos         (in_y_pos),
    .in_alpha_in      (in_alpha_in),
    .cmd              (cmd),
    .status           (status),
    .out_strobe       (out_strobe),
    .out_shadow_alpha (out_shadow_alpha)
  );

endmodule
